// ===== rtl/sphc_pkg.sv =====
// Shared types and constants for the solenoid pulse-and-hold controller.
// No dependencies.
package sphc_pkg;

    localparam int CHANNELS = 16;
    localparam int IDX_W    = $clog2(CHANNELS);
    localparam int CNT_W    = $clog2(CHANNELS + 1);

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_SOL_EVT  = 3'd1,
        MODE_SW_EVT   = 3'd2,
        MODE_LIGHT    = 3'd3,
        MODE_ADD_SOL  = 3'd4,
        MODE_ADD_FLSH = 3'd5,
        MODE_ADD_LAMP = 3'd6,
        MODE_NONE     = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_SOLENOID = 2'd1,
        KIND_FLASHER  = 2'd2,
        KIND_LAMP     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_FLUSH = 2'd2
    } state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] event_number;
        logic       event_value;
        logic [7:0] pin_number;
        logic [7:0] drive_level;
        logic [7:0] min_pulse;
        logic [7:0] max_pulse;
        logic [7:0] hold_level;
        logic [7:0] hold_delay;
        logic [7:0] fast_switch;
    } in_word_t;

    typedef struct packed {
        logic [3:0] channel;
        logic [7:0] out_pin;
        logic [7:0] duty;
        logic       last;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic last_idx;
        logic empty;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/solenoid_pulse_hold_controller_unit.sv =====
// Solenoid pulse-and-hold controller: top level.
// Depends on sphc_pkg, sphc_ctrl, sphc_datapath.
//
// Input channel cmd_valid/cmd_stall/cmd carries one word per tick, device
// event or channel add. Output channel wr_valid/wr_stall/wr carries the
// duty writes of a word; the final write of an input word has last set.
// A tick or event word walks the channel table one channel per cycle,
// except while a receiver stall holds the scan. cmd_stall is high while a
// word is in progress; one word is handled at a time.
// Writes go through a one-word pending register and an output register, so
// a stall on wr holds the scan only when a third write would be needed.
// Reset clears the ms clock, the channel count and all channel flags; the
// table contents are only read for channels that have been added.
module solenoid_pulse_hold_controller_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  sphc_pkg::in_word_t   cmd,
    output logic                 wr_valid,
    input  logic                 wr_stall,
    output sphc_pkg::out_word_t  wr
);

    sphc_pkg::cmd_t    ctl;
    sphc_pkg::status_t status;

    sphc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .mode      (cmd.mode),
        .status    (status),
        .busy      (cmd_stall),
        .ctl       (ctl)
    );

    sphc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .ctl      (ctl),
        .wr_stall (wr_stall),
        .status   (status),
        .wr_valid (wr_valid),
        .wr       (wr)
    );

endmodule

// ===== rtl/sphc_ctrl.sv =====
// Sequencer for the channel scan and result flush.
// Depends on sphc_pkg.
module sphc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic [2:0]          mode,
    input  sphc_pkg::status_t   status,
    output logic                busy,
    output sphc_pkg::cmd_t      ctl
);

    sphc_pkg::state_t state_reg, state_next;
    logic accept;

    assign accept = cmd_valid && (state_reg == sphc_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sphc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sphc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode <= sphc_pkg::MODE_LIGHT && !status.empty)
                        state_next = sphc_pkg::ST_SCAN;
                    else
                        state_next = sphc_pkg::ST_FLUSH;
                end
            end
            sphc_pkg::ST_SCAN:
            begin
                if (ctl.step && status.last_idx)
                    state_next = sphc_pkg::ST_FLUSH;
            end
            sphc_pkg::ST_FLUSH:
            begin
                if (!status.pend_valid || status.out_free)
                    state_next = sphc_pkg::ST_IDLE;
            end
            default:
                state_next = sphc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != sphc_pkg::ST_IDLE);
        ctl.load  = accept;
        // hold the scan while a new write finds pending full and the output stage full and stalled
        ctl.step  = (state_reg == sphc_pkg::ST_SCAN) &&
                    !(status.hit && status.pend_valid && !status.out_free);
        ctl.flush = (state_reg == sphc_pkg::ST_FLUSH) && status.pend_valid &&
                    status.out_free;
    end

endmodule

// ===== rtl/sphc_datapath.sv =====
// Channel tables, per-channel update logic, pending write and output stage.
// Depends on sphc_pkg.
module sphc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sphc_pkg::in_word_t   cmd,
    input  sphc_pkg::cmd_t       ctl,
    input  logic                 wr_stall,
    output sphc_pkg::status_t    status,
    output logic                 wr_valid,
    output sphc_pkg::out_word_t  wr
);

    localparam int N = sphc_pkg::CHANNELS;

    logic [1:0]  kind_table   [N];
    logic [7:0]  number_table [N];
    logic [7:0]  pin_table    [N];
    logic [7:0]  power_table  [N];
    logic [23:0] timing_table [N];
    logic [15:0] hold_table   [N];
    logic [31:0] stamp_table  [N];
    logic [2:0]  flag_reg     [N];

    logic [31:0]                  now_reg;
    logic [sphc_pkg::CNT_W-1:0]   count_reg;
    logic [sphc_pkg::IDX_W-1:0]   idx_reg;
    sphc_pkg::in_word_t           evt_reg;
    logic                         pend_valid_reg;
    sphc_pkg::out_word_t          pend_reg;
    logic                         out_valid_reg;
    sphc_pkg::out_word_t          out_reg;

    // current channel decode
    logic [1:0]  k;
    logic [2:0]  f, f_new;
    logic [31:0] el;
    logic [7:0]  minp, maxp, hdel;
    logic        hit, fire;
    logic [7:0]  duty;
    logic        add_ok, out_free, is_add;
    logic [sphc_pkg::CNT_W-1:0] cnt_m1;

    assign k    = kind_table[idx_reg];
    assign f    = flag_reg[idx_reg];
    assign el   = now_reg - stamp_table[idx_reg];
    assign minp = timing_table[idx_reg][7:0];
    assign maxp = timing_table[idx_reg][15:8];
    assign hdel = timing_table[idx_reg][23:16];

    // flag bits: 0 active, 1 release scheduled, 2 lamp on
    always_comb
    begin
        hit   = 1'b0;
        fire  = 1'b0;
        duty  = 8'd0;
        f_new = f;
        unique case (evt_reg.mode)
            sphc_pkg::MODE_TICK:
            begin
                if (f[0])
                begin
                    if ((f[1] && el > {24'd0, minp}) ||
                        (maxp != 8'd0 && el > {24'd0, maxp}))
                    begin
                        hit   = 1'b1;
                        f_new = {f[2], 2'b00};
                    end
                    else if (hdel != 8'd0 && el > {24'd0, hdel})
                    begin
                        hit  = 1'b1;
                        duty = hold_table[idx_reg][7:0];
                    end
                end
            end
            sphc_pkg::MODE_SOL_EVT:
            begin
                if ((k == sphc_pkg::KIND_SOLENOID || k == sphc_pkg::KIND_FLASHER) &&
                    number_table[idx_reg] == evt_reg.event_number)
                begin
                    if (evt_reg.event_value && !f[0])
                    begin
                        fire = 1'b1;
                    end
                    else if (!evt_reg.event_value && f[0])
                    begin
                        if (minp != 8'd0 && el < {24'd0, minp})
                            f_new = f | 3'b010;
                        else
                        begin
                            hit   = 1'b1;
                            f_new = {f[2], 2'b00};
                        end
                    end
                end
            end
            sphc_pkg::MODE_SW_EVT:
            begin
                if (k == sphc_pkg::KIND_SOLENOID &&
                    hold_table[idx_reg][15:8] == evt_reg.event_number)
                begin
                    if (evt_reg.event_value)
                        fire = 1'b1;
                    else if (f[0])
                    begin
                        hit   = 1'b1;
                        f_new = {f[2], 2'b00};
                    end
                end
            end
            sphc_pkg::MODE_LIGHT:
            begin
                if (k == sphc_pkg::KIND_LAMP &&
                    number_table[idx_reg] == evt_reg.event_number)
                begin
                    if (evt_reg.event_value)
                    begin
                        hit   = 1'b1;
                        duty  = power_table[idx_reg];
                        f_new = f | 3'b100;
                    end
                    else if (f[2])
                    begin
                        hit   = 1'b1;
                        f_new = f & 3'b011;
                    end
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
        if (fire)
        begin
            hit   = 1'b1;
            duty  = power_table[idx_reg];
            f_new = f | 3'b001;
        end
    end

    assign add_ok   = (count_reg < sphc_pkg::CNT_W'(N));
    assign out_free = !out_valid_reg || !wr_stall;
    assign cnt_m1   = count_reg - sphc_pkg::CNT_W'(1);
    assign is_add   = (cmd.mode == sphc_pkg::MODE_ADD_SOL ||
                       cmd.mode == sphc_pkg::MODE_ADD_FLSH ||
                       cmd.mode == sphc_pkg::MODE_ADD_LAMP);

    always_comb
    begin
        status.hit        = hit;
        status.last_idx   = ({1'b0, idx_reg} == cnt_m1);
        status.empty      = (count_reg == '0);
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
    end

    assign wr_valid = out_valid_reg;
    assign wr       = out_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < N; i++)
                flag_reg[i] <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                idx_reg        <= '0;
                pend_valid_reg <= is_add && add_ok;
                if (cmd.mode == sphc_pkg::MODE_TICK)
                    now_reg <= now_reg + 32'd1;
                if (is_add && add_ok)
                begin
                    flag_reg[count_reg[sphc_pkg::IDX_W-1:0]] <= '0;
                    count_reg <= count_reg + sphc_pkg::CNT_W'(1);
                end
            end
            if (ctl.step)
            begin
                flag_reg[idx_reg] <= f_new;
                idx_reg           <= idx_reg + sphc_pkg::IDX_W'(1);
                if (hit)
                    pend_valid_reg <= 1'b1;
            end
            if (ctl.flush)
                pend_valid_reg <= 1'b0;

            if ((ctl.step && hit && pend_valid_reg) || ctl.flush)
                out_valid_reg <= 1'b1;
            else if (!wr_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers and tables
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            evt_reg <= cmd;
            if (add_ok)
            begin
                pend_reg.channel <= count_reg[3:0];
                pend_reg.out_pin <= cmd.pin_number;
                pend_reg.duty    <= 8'd0;
                pend_reg.last    <= 1'b0;
            end
            if (is_add && add_ok)
            begin
                kind_table[count_reg[sphc_pkg::IDX_W-1:0]]   <=
                    (cmd.mode == sphc_pkg::MODE_ADD_SOL)  ? sphc_pkg::KIND_SOLENOID :
                    (cmd.mode == sphc_pkg::MODE_ADD_FLSH) ? sphc_pkg::KIND_FLASHER :
                                                            sphc_pkg::KIND_LAMP;
                number_table[count_reg[sphc_pkg::IDX_W-1:0]] <= cmd.event_number;
                pin_table[count_reg[sphc_pkg::IDX_W-1:0]]    <= cmd.pin_number;
                power_table[count_reg[sphc_pkg::IDX_W-1:0]]  <= cmd.drive_level;
                if (cmd.mode == sphc_pkg::MODE_ADD_SOL)
                begin
                    timing_table[count_reg[sphc_pkg::IDX_W-1:0]] <=
                        {cmd.hold_delay, cmd.max_pulse, cmd.min_pulse};
                    hold_table[count_reg[sphc_pkg::IDX_W-1:0]]   <=
                        {cmd.fast_switch, cmd.hold_level};
                end
                else
                begin
                    timing_table[count_reg[sphc_pkg::IDX_W-1:0]] <= '0;
                    hold_table[count_reg[sphc_pkg::IDX_W-1:0]]   <= '0;
                end
            end
        end
        if (ctl.step)
        begin
            if (fire)
                stamp_table[idx_reg] <= now_reg;
            if (hit)
            begin
                pend_reg.channel <= 4'(idx_reg);
                pend_reg.out_pin <= pin_table[idx_reg];
                pend_reg.duty    <= duty;
                pend_reg.last    <= 1'b0;
                if (pend_valid_reg)
                    out_reg <= pend_reg;
            end
        end
        if (ctl.flush)
            out_reg <= {pend_reg.channel, pend_reg.out_pin, pend_reg.duty, 1'b1};
    end

endmodule
